// ===== src/matrix_inverse_4x4_macros.svh =====
// assertion helpers used by the top-level rtl
`ifndef MATRIX_INVERSE_4X4_MACROS_SVH
`define MATRIX_INVERSE_4X4_MACROS_SVH

// same-cycle implication, disabled in reset
`define MINV_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled in reset
`define MINV_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/minv_pkg.sv =====
`timescale 1ns / 1ps

package minv_pkg;

	// one result transaction as produced by the core
	typedef struct packed {
		logic [31:0] value;
		logic [3:0]  index;
		logic        singular;
		logic        saturated;
		logic        last;
	} res_t;

	localparam logic [3:0] LAST_INDEX = 4'd15;

endpackage

// ===== src/minv_ifs.sv =====
`timescale 1ns / 1ps

// element load channel
interface minv_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] element_value;
	logic        restart;

	modport source(output valid, element_value, restart, input ready);
	modport sink(input valid, element_value, restart, output ready);
endinterface

// inverse result channel
interface minv_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] result_value;
	logic [3:0]  result_index;
	logic        singular;
	logic        saturated;
	logic        last_element;

	modport source(output valid, result_value, result_index, singular, saturated,
		last_element, input ready);
	modport sink(input valid, result_value, result_index, singular, saturated,
		last_element, output ready);
endinterface

// ===== src/minv_elem_mem.sv =====
`timescale 1ns / 1ps

module minv_elem_mem #(
	parameter int ELEM_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [3:0]            wr_addr,
	input  logic [ELEM_WIDTH-1:0] wr_data,
	input  logic [3:0]            rd_addr_a,
	input  logic [3:0]            rd_addr_b,
	output logic [ELEM_WIDTH-1:0] rd_data_a,
	output logic [ELEM_WIDTH-1:0] rd_data_b
);

	logic [ELEM_WIDTH-1:0] mem_q [16];

	// single write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// two registered read ports
	always_ff @(posedge clk) begin
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

// ===== src/minv_core.sv =====
`timescale 1ns / 1ps

module minv_core import minv_pkg::*; #(
	parameter int ELEM_WIDTH = 32,
	parameter int FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic [3:0]            rd_addr_a,
	output logic [3:0]            rd_addr_b,
	input  logic [ELEM_WIDTH-1:0] rd_data_a,
	input  logic [ELEM_WIDTH-1:0] rd_data_b,
	output logic                  res_valid,
	input  logic                  res_take,
	output res_t                  res
);

	localparam int EW  = ELEM_WIDTH;
	localparam int AW  = 4 * EW + 3;
	localparam int AJ  = 3 * EW + 2;
	localparam int NW  = 3 * EW + 2 * FRAC_BITS;
	localparam int QW  = EW + 1;
	localparam int BW  = $clog2(EW);
	localparam int DCW = $clog2(NW);
	localparam bit IDN_SAT = (FRAC_BITS >= ELEM_WIDTH - 1);
	localparam logic [EW-1:0] MAXV  = {1'b0, {(EW-1){1'b1}}};
	localparam logic [EW-1:0] ONE_V = IDN_SAT ? MAXV : (EW'(1) << FRAC_BITS);
	localparam logic [QW-1:0] LIM_P = QW'(MAXV);
	localparam logic [QW-1:0] LIM_N = QW'(MAXV) + QW'(1);

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_RD   = 11'b00000000010,
		S_LD   = 11'b00000000100,
		S_MUL  = 11'b00000001000,
		S_WADJ = 11'b00000010000,
		S_DCHK = 11'b00000100000,
		S_IDN  = 11'b00001000000,
		S_DSET = 11'b00010000000,
		S_DIV  = 11'b00100000000,
		S_DFIN = 11'b01000000000,
		S_OUT  = 11'b10000000000
	} state_t;

	// one multiply-accumulate step of a 3x3 minor
	typedef struct packed {
		logic [1:0] ra;
		logic [1:0] rb;
		logic [1:0] ca;
		logic [1:0] cb;
		logic       mc_tmp;
		logic       dst_acc;
		logic       clr;
		logic       neg;
	} op_t;

	function automatic op_t op_decode(input logic [3:0] step);
		op_t o;
		o = '0;
		unique case (step)
			4'd0: o = '{2'd1, 2'd1, 2'd2, 2'd2, 1'b0, 1'b0, 1'b1, 1'b0};
			4'd1: o = '{2'd1, 2'd2, 2'd2, 2'd1, 1'b0, 1'b0, 1'b0, 1'b1};
			4'd2: o = '{2'd0, 2'd0, 2'd0, 2'd0, 1'b1, 1'b1, 1'b1, 1'b0};
			4'd3: o = '{2'd1, 2'd0, 2'd2, 2'd2, 1'b0, 1'b0, 1'b1, 1'b0};
			4'd4: o = '{2'd1, 2'd2, 2'd2, 2'd0, 1'b0, 1'b0, 1'b0, 1'b1};
			4'd5: o = '{2'd0, 2'd1, 2'd0, 2'd0, 1'b1, 1'b1, 1'b0, 1'b1};
			4'd6: o = '{2'd1, 2'd0, 2'd2, 2'd1, 1'b0, 1'b0, 1'b1, 1'b0};
			4'd7: o = '{2'd1, 2'd1, 2'd2, 2'd0, 1'b0, 1'b0, 1'b0, 1'b1};
			4'd8: o = '{2'd0, 2'd2, 2'd0, 2'd0, 1'b1, 1'b1, 1'b0, 1'b0};
			default: o = '0;
		endcase
		return o;
	endfunction

	// index that skips the excluded row or column
	function automatic logic [1:0] skip(input logic [1:0] v, input logic [1:0] excl);
		return (v < excl) ? v : v + 2'd1;
	endfunction

	state_t                state_q;
	logic [3:0]            p_q;
	logic [3:0]            step_q;
	logic [3:0]            k_q;
	logic                  det_ph_q;
	logic                  sing_q;
	logic                  dneg_q;
	logic                  qneg_q;
	logic                  ovf_q;
	logic [BW-1:0]         bit_q;
	logic [DCW-1:0]        dcnt_q;
	logic signed [AW-1:0]  tmp_q;
	logic signed [AW-1:0]  acc_q;
	logic [AW-1:0]         mc_q;
	logic [EW-1:0]         mr_q;
	logic [AW-1:0]         dvs_q;
	logic [AW-1:0]         rem_q;
	logic [NW-1:0]         num_q;
	logic [QW-1:0]         quo_q;
	logic signed [AJ-1:0]  adj_q [16];
	res_t                  res_q;

	op_t                   op;
	logic                  neg_eff;
	logic                  mul_last;
	logic [AW-1:0]         add_a;
	logic [AW-1:0]         add_b;
	logic                  add_sub;
	logic [AW-1:0]         sum;
	logic [AW-1:0]         div_a;
	logic signed [AW-1:0]  adj_k_ext;
	logic signed [AW-1:0]  adj_det_ext;
	logic [QW-1:0]         quo_lim;
	logic                  quo_sat;
	logic [QW-1:0]         quo_mag;
	logic [QW-1:0]         quo_sgn;

	// current step and operand addressing
	always_comb begin
		op = det_ph_q ? op_t'{2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 1'b1, (step_q == 4'd0), 1'b0}
			: op_decode(step_q);
		neg_eff = op.neg ^ (op.dst_acc & ~det_ph_q & (p_q[2] ^ p_q[0]));
		rd_addr_a = det_ph_q ? {2'b00, step_q[1:0]}
			: {skip(op.rb, p_q[1:0]), skip(op.ra, p_q[3:2])};
		rd_addr_b = {skip(op.cb, p_q[1:0]), skip(op.ca, p_q[3:2])};
	end

	assign mul_last    = (bit_q == BW'(EW - 1));
	assign adj_k_ext   = AW'(adj_q[k_q]);
	assign adj_det_ext = AW'(adj_q[{step_q[1:0], 2'b00}]);
	assign div_a       = {rem_q[AW-2:0], num_q[NW-1]};

	// the shared wide adder
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			S_MUL: begin
				add_a   = op.dst_acc ? acc_q : tmp_q;
				add_b   = mr_q[0] ? mc_q : '0;
				add_sub = neg_eff ^ mul_last;
			end
			S_DCHK: begin
				add_b   = acc_q;
				add_sub = 1'b1;
			end
			S_DSET: begin
				add_b   = adj_k_ext;
				add_sub = 1'b1;
			end
			S_DIV: begin
				add_a   = div_a;
				add_b   = dvs_q;
				add_sub = 1'b1;
			end
			default: begin
				add_sub = 1'b0;
			end
		endcase
		sum = add_a + (add_sub ? ~add_b : add_b) + AW'(add_sub);
	end

	// quotient clipping
	always_comb begin
		quo_lim = qneg_q ? LIM_N : LIM_P;
		quo_sat = ovf_q | (quo_q > quo_lim);
		quo_mag = quo_sat ? quo_lim : quo_q;
		quo_sgn = qneg_q ? (~quo_mag + QW'(1)) : quo_mag;
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			p_q      <= '0;
			step_q   <= '0;
			k_q      <= '0;
			det_ph_q <= 1'b0;
			bit_q    <= '0;
			dcnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q  <= S_RD;
						p_q      <= '0;
						step_q   <= '0;
						det_ph_q <= 1'b0;
					end
				end
				S_RD: state_q <= S_LD;
				S_LD: begin
					bit_q   <= '0;
					state_q <= S_MUL;
				end
				S_MUL: begin
					bit_q <= bit_q + BW'(1);
					if (mul_last) begin
						if (det_ph_q) begin
							if (step_q == 4'd3) begin
								state_q <= S_DCHK;
							end else begin
								step_q  <= step_q + 4'd1;
								state_q <= S_RD;
							end
						end else if (step_q == 4'd8) begin
							state_q <= S_WADJ;
						end else begin
							step_q  <= step_q + 4'd1;
							state_q <= S_RD;
						end
					end
				end
				S_WADJ: begin
					step_q  <= '0;
					state_q <= S_RD;
					if (p_q == LAST_INDEX) begin
						det_ph_q <= 1'b1;
					end else begin
						p_q <= p_q + 4'd1;
					end
				end
				S_DCHK: begin
					k_q     <= '0;
					state_q <= (acc_q == '0) ? S_IDN : S_DSET;
				end
				S_IDN: state_q <= S_OUT;
				S_DSET: begin
					dcnt_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					dcnt_q <= dcnt_q + DCW'(1);
					if (dcnt_q == DCW'(NW - 1)) begin
						state_q <= S_DFIN;
					end
				end
				S_DFIN: state_q <= S_OUT;
				S_OUT: begin
					if (res_take) begin
						if (k_q == LAST_INDEX) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + 4'd1;
							state_q <= sing_q ? S_IDN : S_DSET;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_LD: begin
				mr_q <= rd_data_a;
				if (det_ph_q) begin
					mc_q <= adj_det_ext;
				end else if (op.mc_tmp) begin
					mc_q <= tmp_q;
				end else begin
					mc_q <= AW'(signed'(rd_data_b));
				end
				if (op.clr) begin
					if (op.dst_acc) begin
						acc_q <= '0;
					end else begin
						tmp_q <= '0;
					end
				end
			end
			S_MUL: begin
				if (op.dst_acc) begin
					acc_q <= sum;
				end else begin
					tmp_q <= sum;
				end
				mc_q <= mc_q << 1;
				mr_q <= mr_q >> 1;
			end
			S_WADJ: adj_q[p_q] <= acc_q[AJ-1:0];
			S_DCHK: begin
				sing_q <= (acc_q == '0);
				dneg_q <= acc_q[AW-1];
				dvs_q  <= acc_q[AW-1] ? sum : acc_q;
			end
			S_IDN: begin
				res_q.value     <= (k_q[1:0] == k_q[3:2]) ? 32'(ONE_V) : '0;
				res_q.index     <= k_q;
				res_q.singular  <= 1'b1;
				res_q.saturated <= IDN_SAT && (k_q[1:0] == k_q[3:2]);
				res_q.last      <= (k_q == LAST_INDEX);
			end
			S_DSET: begin
				num_q  <= {(adj_k_ext[AW-1] ? sum[3*EW-1:0] : adj_k_ext[3*EW-1:0]),
					{(2 * FRAC_BITS){1'b0}}};
				qneg_q <= adj_k_ext[AW-1] ^ dneg_q;
				rem_q  <= '0;
				quo_q  <= '0;
				ovf_q  <= 1'b0;
			end
			S_DIV: begin
				rem_q <= sum[AW-1] ? div_a : sum;
				quo_q <= {quo_q[QW-2:0], ~sum[AW-1]};
				ovf_q <= ovf_q | quo_q[QW-1];
				num_q <= num_q << 1;
			end
			S_DFIN: begin
				res_q.value     <= 32'(signed'(quo_sgn[EW-1:0]));
				res_q.index     <= k_q;
				res_q.singular  <= 1'b0;
				res_q.saturated <= quo_sat;
				res_q.last      <= (k_q == LAST_INDEX);
			end
			default: begin
				res_q <= res_q;
			end
		endcase
	end

	assign busy      = (state_q != S_IDLE);
	assign res_valid = (state_q == S_OUT);
	assign res       = res_q;

endmodule

// ===== src/matrix_inverse_4x4.sv =====
`timescale 1ns / 1ps
// channel     dir  payload
// elem_ch     in   element_value[31:0], restart
// result_ch   out  result_value[31:0], result_index[3:0], singular, saturated, last_element
//
// elements load at one per cycle; after the sixteenth the block is busy and not ready.
// one wide adder does all work: 144 adjugate steps and 4 determinant steps, then
// a division per result (a singular matrix skips the division).
// a result stalled at the output holds the core; the last one waits while the next loads.
// arst_n clears control state only; the element store has no reset.

module matrix_inverse_4x4 import minv_pkg::*; #(
	parameter int FRAC_BITS  = 16,
	parameter int ELEM_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	minv_in_if.sink    elem_ch,
	minv_out_if.source result_ch
);

	`include "matrix_inverse_4x4_macros.svh"

	logic [3:0]            cnt_q;
	logic [3:0]            wr_idx;
	logic                  in_fire;
	logic                  start;
	logic                  core_busy;
	logic [3:0]            rd_addr_a;
	logic [3:0]            rd_addr_b;
	logic [ELEM_WIDTH-1:0] rd_data_a;
	logic [ELEM_WIDTH-1:0] rd_data_b;
	logic                  core_valid;
	logic                  take;
	res_t                  core_res;
	res_t                  out_q;
	logic                  out_valid_q;
	logic                  sing_off;

	// load counting with restart
	assign elem_ch.ready = ~core_busy;
	assign in_fire       = elem_ch.valid & elem_ch.ready;
	assign wr_idx        = elem_ch.restart ? 4'd0 : cnt_q;
	assign start         = in_fire & (wr_idx == LAST_INDEX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (in_fire) begin
			cnt_q <= wr_idx + 4'd1;
		end
	end

	minv_elem_mem #(
		.ELEM_WIDTH(ELEM_WIDTH)
	) u_mem (
		.clk      (clk),
		.wr_en    (in_fire),
		.wr_addr  (wr_idx),
		.wr_data  (elem_ch.element_value[ELEM_WIDTH-1:0]),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b)
	);

	minv_core #(
		.ELEM_WIDTH(ELEM_WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (core_busy),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b),
		.res_valid(core_valid),
		.res_take (take),
		.res      (core_res)
	);

	// output register
	assign take = core_valid & (~out_valid_q | result_ch.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (result_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= core_res;
		end
	end

	assign result_ch.valid        = out_valid_q;
	assign result_ch.result_value = out_q.value;
	assign result_ch.result_index = out_q.index;
	assign result_ch.singular     = out_q.singular;
	assign result_ch.saturated    = out_q.saturated;
	assign result_ch.last_element = out_q.last;

	// checks
	assign sing_off = out_valid_q & out_q.singular & (out_q.index[1:0] != out_q.index[3:2]);

	`MINV_ASSERT_NOW(a_start_idle, start, !core_busy, "matrix started while core busy")
	`MINV_ASSERT_NOW(a_last_idx, out_valid_q && out_q.last, out_q.index == LAST_INDEX, "bad last")
	`MINV_ASSERT_NEXT(a_done_idle, take && core_res.last, !core_busy, "busy after last result")
	`MINV_ASSERT_NOW(a_sing_offdiag, sing_off, out_q.value == '0, "singular off-diagonal not zero")

endmodule
